// ===== rtl/fenw_pkg.sv =====
// ----------------------------------------------------------------------------
// fenw_pkg
// Shared widths, constants and command codes for the modular Fenwick tree.
// ----------------------------------------------------------------------------
package fenw_pkg;

  // field widths
  localparam int POS_W = 13;
  localparam int VAL_W = 30;
  // walk index: one bit above a position so the upward step cannot wrap
  localparam int IDX_W = POS_W + 1;

  // residue modulus, fits in the value width
  localparam logic [VAL_W-1:0] MODULUS = 30'd1000000007;

  // size register value after reset
  localparam logic [POS_W-1:0] SIZE_RESET = 13'd4096;

  // command codes
  typedef enum logic {
    CMD_ADD   = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_t;

endpackage

// ===== rtl/fenw_mod_add.sv =====
// ----------------------------------------------------------------------------
// fenw_mod_add
// Shared modular adder: one wide add, one compare and a conditional subtract.
// ----------------------------------------------------------------------------
module fenw_mod_add
  import fenw_pkg::*;
(
  input  logic [VAL_W-1:0] a,
  input  logic [VAL_W-1:0] b,
  output logic [VAL_W-1:0] sum
);

  logic [VAL_W:0] raw;

  // add, then fold back once below the modulus
  always_comb begin
    raw = {1'b0, a} + {1'b0, b};
    if (raw >= {1'b0, MODULUS}) begin
      raw = raw - {1'b0, MODULUS};
    end
    sum = raw[VAL_W-1:0];
  end

endmodule

// ===== rtl/fenw_node_ram.sv =====
// ----------------------------------------------------------------------------
// fenw_node_ram
// Tree node store: one write port and one read port with registered data.
// ----------------------------------------------------------------------------
module fenw_node_ram
  import fenw_pkg::*;
#(
  parameter  int DEPTH  = 4096,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [VAL_W-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [VAL_W-1:0]  rdata
);

  logic [VAL_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/fenwick_tree_mod_prefix_sum.sv =====
// ----------------------------------------------------------------------------
// fenwick_tree_mod_prefix_sum
// Binary indexed tree of prefix sums modulo 1000000007: add and query walks.
// ----------------------------------------------------------------------------
// The walk reads one tree node per cycle through the node store's single read
// port; a query result is registered in ST_FINISH after its walk and waits there
// while the result side stalls.
// One item at a time: a new command is taken only in ST_IDLE, once the last
// item is through.
// Reset: synchronous; then a clearing pass zeroes each node, input stalled.
module fenwick_tree_mod_prefix_sum
  import fenw_pkg::*;
#(
  parameter int MAX_POSITIONS = 4096
) (
  input  logic             clk,
  input  logic             rst,
  // size register write
  input  logic             cfg_we,
  input  logic [POS_W-1:0] cfg_wdata,
  // command channel
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             command,
  input  logic [POS_W-1:0] position,
  input  logic [VAL_W-1:0] addend,
  // result channel
  output logic             out_valid,
  input  logic             out_stall,
  output logic [VAL_W-1:0] prefix_sum
);

  localparam int ADDR_W = (MAX_POSITIONS > 1) ? $clog2(MAX_POSITIONS) : 1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_FINISH
  } state_t;

  state_t            state;
  logic [POS_W-1:0]  tree_size;
  logic [POS_W-1:0]  active_size;
  logic [ADDR_W-1:0] clr_addr;
  cmd_t              cmd_q;
  logic [IDX_W-1:0]  idx;
  logic [IDX_W-1:0]  pend_idx;
  logic              pend;
  logic [VAL_W-1:0]  val;
  logic [VAL_W-1:0]  acc;

  logic [IDX_W-1:0]  lowbit;
  logic [IDX_W-1:0]  idx_next;
  logic              in_range;
  logic [POS_W-1:0]  start_pos;
  logic [VAL_W-1:0]  unit_a;
  logic [VAL_W-1:0]  unit_b;
  logic [VAL_W-1:0]  unit_sum;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [VAL_W-1:0]  ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [VAL_W-1:0]  ram_rdata;

  // size register saturated to the store depth
  always_comb begin
    active_size = tree_size;
    if (32'(tree_size) > 32'(MAX_POSITIONS)) begin
      active_size = POS_W'(MAX_POSITIONS);
    end
  end

  // query positions beyond the size are clamped at transfer
  always_comb begin
    start_pos = position;
    if (command == CMD_QUERY && position > active_size) begin
      start_pos = active_size;
    end
  end

  // walk step: add or strip the lowest set bit
  always_comb begin
    lowbit = idx & (~idx + IDX_W'(1));
    if (cmd_q == CMD_ADD) begin
      idx_next = idx + lowbit;
      in_range = (idx != '0) && (idx <= {1'b0, active_size});
    end else begin
      idx_next = idx - lowbit;
      in_range = (idx != '0);
    end
  end

  // shared adder operands: node update, prefix accumulate, or addend reduction
  always_comb begin
    if (pend) begin
      unit_a = ram_rdata;
      unit_b = (cmd_q == CMD_QUERY) ? acc : val;
    end else begin
      unit_a = val;
      unit_b = '0;
    end
  end

  fenw_mod_add u_mod_add (
    .a   (unit_a),
    .b   (unit_b),
    .sum (unit_sum)
  );

  // node store ports
  always_comb begin
    ram_re    = (state == ST_WALK) && in_range;
    ram_raddr = ADDR_W'(idx - IDX_W'(1));
    if (state == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else begin
      ram_we    = (state == ST_WALK) && pend && (cmd_q == CMD_ADD);
      ram_waddr = ADDR_W'(pend_idx - IDX_W'(1));
      ram_wdata = unit_sum;
    end
  end

  fenw_node_ram #(
    .DEPTH (MAX_POSITIONS)
  ) u_node_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_stall = (state != ST_IDLE);

  // sequencer, size register and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      tree_size <= SIZE_RESET;
      clr_addr  <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        tree_size <= cfg_wdata;
      end
      // a finishing query reloads the output register itself
      if (out_valid && !out_stall && state != ST_FINISH) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (clr_addr == ADDR_W'(MAX_POSITIONS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          pend <= 1'b0;
          if (in_valid) begin
            cmd_q <= cmd_t'(command);
            idx   <= {1'b0, start_pos};
            val   <= addend;
            acc   <= '0;
            state <= ST_WALK;
          end
        end
        ST_WALK: begin
          // retire the node read last cycle
          if (pend) begin
            if (cmd_q == CMD_QUERY) begin
              acc <= unit_sum;
            end
          end else begin
            val <= unit_sum;
          end
          // issue the next node read
          pend     <= in_range;
          pend_idx <= idx;
          if (in_range) begin
            idx <= idx_next;
          end else begin
            state <= (cmd_q == CMD_QUERY) ? ST_FINISH : ST_IDLE;
          end
        end
        ST_FINISH: begin
          pend <= 1'b0;
          if (!out_valid || !out_stall) begin
            out_valid  <= 1'b1;
            prefix_sum <= acc;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // a new result only comes from a finished query walk
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_FINISH)
    else $error("result raised without a finished query");

  // node writes only during the clearing pass or an add walk
  assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == ST_CLEAR) || (state == ST_WALK && cmd_q == CMD_ADD))
    else $error("node store written outside a clear or add walk");

  // accumulated prefix sum stays a residue
  assert property (@(posedge clk) disable iff (rst)
    state == ST_FINISH |-> acc < MODULUS)
    else $error("prefix sum not reduced");

  // a query walk never reads beyond the active size
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK && cmd_q == CMD_QUERY) |-> idx <= {1'b0, active_size})
    else $error("query walk beyond active size");

  // an add retires a node only with a reduced addend
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK && pend && cmd_q == CMD_ADD) |-> val < MODULUS)
    else $error("addend not reduced before node update");
`endif

endmodule

// ===== tb/fenwick_tree_mod_prefix_sum_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fenwick_tree_mod_prefix_sum_tb
// Drives add and prefix-sum commands into the modular Fenwick tree and checks
// every returned sum against a behavioural tree kept alongside the block or a table value.
// A short table of directed commands comes first, then random phases at a
// range of size settings, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module fenwick_tree_mod_prefix_sum_tb;
  import fenw_pkg::*;

  localparam int MAX_POS = 4096;
  localparam int PHASE_ITEMS = 200;
  // longest walk of one item plus margin, in cycles
  localparam int DRAIN_CYCLES = 24;
  localparam int LONG_HOLD = 250;

  // kinds of row in the directed table
  typedef enum logic {
    ROW_ITEM,
    ROW_SIZE
  } row_kind_t;

  // one directed row: a command, or a size write carried in arg
  typedef struct packed {
    row_kind_t        kind;
    cmd_t             cmd;
    logic [POS_W-1:0] arg;
    logic [VAL_W-1:0] val;
    logic             known;
    logic [VAL_W-1:0] want;
  } stim_row_t;

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [POS_W-1:0] cfg_wdata;
  logic             in_valid;
  logic             in_stall;
  logic             command;
  logic [POS_W-1:0] position;
  logic [VAL_W-1:0] addend;
  logic             out_valid;
  logic             out_stall;
  logic [VAL_W-1:0] prefix_sum;

  // shadow tree and size register
  logic [VAL_W-1:0] node_sum [1:MAX_POS];
  logic [POS_W-1:0] size_shadow;

  logic [VAL_W-1:0] sums_due [$];
  int               mismatches = 0;
  int               results_taken = 0;
  // no random idling on either side while set
  bit               steady = 1'b0;

  stim_row_t directed [0:26] = '{
    // empty tree: everything reads zero, clamped or not
    '{ROW_ITEM, CMD_QUERY, 13'd0,    30'd0,          1'b1, 30'd0},
    '{ROW_ITEM, CMD_QUERY, 13'd4096, 30'd0,          1'b1, 30'd0},
    '{ROW_ITEM, CMD_QUERY, 13'd8191, 30'd0,          1'b1, 30'd0},
    // largest residue, last position, ignored adds, unreduced addends
    '{ROW_ITEM, CMD_ADD,   13'd1,    30'd1000000006, 1'b0, 30'd0},
    '{ROW_ITEM, CMD_ADD,   13'd4096, 30'd1,          1'b0, 30'd0},
    '{ROW_ITEM, CMD_ADD,   13'd0,    30'd5,          1'b0, 30'd0},
    '{ROW_ITEM, CMD_ADD,   13'd3,    30'h3FFF_FFFF,  1'b0, 30'd0},
    '{ROW_ITEM, CMD_ADD,   13'd4095, 30'd1000000007, 1'b0, 30'd0},
    '{ROW_ITEM, CMD_QUERY, 13'd0,    30'd0,          1'b1, 30'd0},
    '{ROW_ITEM, CMD_QUERY, 13'd1,    30'd0,          1'b1, 30'd1000000006},
    '{ROW_ITEM, CMD_QUERY, 13'd4096, 30'd0,          1'b0, 30'd0},
    '{ROW_ITEM, CMD_QUERY, 13'd8191, 30'd0,          1'b0, 30'd0},
    '{ROW_ITEM, CMD_QUERY, 13'd3,    30'd0,          1'b0, 30'd0},
    // size zero: adds dropped, queries answer zero
    '{ROW_SIZE, CMD_ADD,   13'd0,    30'd0,          1'b0, 30'd0},
    '{ROW_ITEM, CMD_ADD,   13'd7,    30'd99,         1'b0, 30'd0},
    '{ROW_ITEM, CMD_QUERY, 13'd4096, 30'd0,          1'b1, 30'd0},
    '{ROW_ITEM, CMD_QUERY, 13'd8191, 30'd0,          1'b1, 30'd0},
    // size above the maximum saturates
    '{ROW_SIZE, CMD_ADD,   13'd8191, 30'd0,          1'b0, 30'd0},
    '{ROW_ITEM, CMD_ADD,   13'd8191, 30'h3FFF_FFFF,  1'b0, 30'd0},
    '{ROW_ITEM, CMD_QUERY, 13'd8191, 30'd0,          1'b0, 30'd0},
    // size one: walk stops after the first node
    '{ROW_SIZE, CMD_ADD,   13'd1,    30'd0,          1'b0, 30'd0},
    '{ROW_ITEM, CMD_ADD,   13'd1,    30'd500,        1'b0, 30'd0},
    '{ROW_ITEM, CMD_ADD,   13'd2,    30'd77,         1'b0, 30'd0},
    '{ROW_ITEM, CMD_QUERY, 13'd4096, 30'd0,          1'b0, 30'd0},
    // back to full size: node two kept what the earlier walks left
    '{ROW_SIZE, CMD_ADD,   13'd4096, 30'd0,          1'b0, 30'd0},
    '{ROW_ITEM, CMD_QUERY, 13'd2,    30'd0,          1'b0, 30'd0},
    '{ROW_ITEM, CMD_ADD,   13'd4096, 30'd0,          1'b0, 30'd0}
  };

  fenwick_tree_mod_prefix_sum dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .command    (command),
    .position   (position),
    .addend     (addend),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .prefix_sum (prefix_sum)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // run limit
  initial begin
    #10ms;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic int unsigned add_mod(input int unsigned a, input int unsigned b);
    int unsigned s;
    s = a + b;
    if (s >= MODULUS) s -= MODULUS;
    return s;
  endfunction

  function automatic int unsigned active_size();
    return (size_shadow > MAX_POS) ? MAX_POS : size_shadow;
  endfunction

  // apply one command to the shadow tree; a query yields a sum
  task automatic apply_to_tree(input cmd_t cmd, input logic [POS_W-1:0] pos,
                               input logic [VAL_W-1:0] val, output bit has_sum,
                               output logic [VAL_W-1:0] sum);
    int unsigned lim;
    int unsigned idx;
    int unsigned v;
    int unsigned acc;
    lim = active_size();
    idx = 32'(pos);
    v = 32'(val);
    acc = 0;
    has_sum = 1'b0;
    sum = '0;
    if (cmd == CMD_ADD) begin
      if (v >= MODULUS) v -= MODULUS;
      // upward walk by the lowest set bit
      if (idx != 0) begin
        while (idx <= lim) begin
          node_sum[idx] = VAL_W'(add_mod(32'(node_sum[idx]), v));
          idx += idx & (~idx + 1);
        end
      end
    end else begin
      if (idx > lim) idx = lim;
      // downward walk, clearing the lowest set bit
      while (idx > 0) begin
        acc = add_mod(acc, 32'(node_sum[idx]));
        idx -= idx & (~idx + 1);
      end
      has_sum = 1'b1;
      sum = VAL_W'(acc);
    end
  endtask

  // offer one command and wait for its transfer; called at a falling edge
  task automatic offer_command(input cmd_t cmd, input logic [POS_W-1:0] pos,
                               input logic [VAL_W-1:0] val, input bit known,
                               input logic [VAL_W-1:0] want);
    int gap;
    bit has_sum;
    logic [VAL_W-1:0] sum;
    gap = steady ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    command  = cmd;
    position = pos;
    addend   = val;
    do @(posedge clk); while (in_stall);
    apply_to_tree(cmd, pos, val, has_sum, sum);
    if (has_sum) sums_due.insert(sums_due.size(), known ? want : sum);
    @(negedge clk);
  endtask

  // size write once the block has gone quiet
  task automatic write_tree_size(input logic [POS_W-1:0] value);
    in_valid = 1'b0;
    while (sums_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we      = 1'b0;
    size_shadow = value;
  endtask

  // result side: random stalls, two long hold-offs, checks every transfer
  initial begin
    int wait_cycles;
    logic [VAL_W-1:0] want;
    out_stall = 1'b0;
    do @(negedge clk); while (rst);
    forever begin
      if (results_taken == 100 || results_taken == 350) begin
        out_stall = 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
      end
      wait_cycles = steady ? 0 : $urandom_range(0, 7);
      if (wait_cycles != 0) begin
        out_stall = 1'b1;
        repeat (wait_cycles) @(negedge clk);
      end
      out_stall = 1'b0;
      do @(posedge clk); while (!out_valid);
      results_taken++;
      if (sums_due.size() == 0) begin
        $error("prefix_sum: expected none, actual %0d", prefix_sum);
        mismatches++;
      end else begin
        want = sums_due.pop_front();
        if (prefix_sum !== want) begin
          $error("prefix_sum: expected %0d, actual %0d", want, prefix_sum);
          mismatches++;
        end
      end
      @(negedge clk);
    end
  end

  // reset, directed table, random phases, drain
  initial begin
    int unsigned lim;
    int roll;
    cmd_t cmd;
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] val;
    logic [POS_W-1:0] phase_size [6];

    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    in_valid  = 1'b0;
    command   = CMD_ADD;
    position  = '0;
    addend    = '0;
    for (int i = 1; i <= MAX_POS; i++) node_sum[i] = '0;
    size_shadow = SIZE_RESET;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed table
    foreach (directed[i]) begin
      if (directed[i].kind == ROW_SIZE)
        write_tree_size(directed[i].arg);
      else
        offer_command(directed[i].cmd, directed[i].arg, directed[i].val,
                      directed[i].known, directed[i].want);
    end

    // random phases over a spread of sizes, extremes included
    phase_size[0] = 13'd4096;
    phase_size[1] = 13'd1;
    phase_size[2] = 13'd8191;
    phase_size[3] = 13'd0;
    phase_size[4] = POS_W'($urandom_range(2, 40));
    phase_size[5] = POS_W'($urandom_range(1, MAX_POS));
    foreach (phase_size[p]) begin
      write_tree_size(phase_size[p]);
      lim = active_size();
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 40 == 0) steady = ($urandom_range(0, 3) == 0);
        cmd = cmd_t'($urandom_range(0, 1));
        // mostly positions inside the tree, some at the edges or far beyond
        roll = $urandom_range(0, 9);
        if (roll == 0)
          pos = POS_W'($urandom_range(0, 8191));
        else if (roll == 1)
          pos = $urandom_range(0, 1) ? POS_W'(lim) : '0;
        else
          pos = (lim == 0) ? '0 : POS_W'($urandom_range(1, lim));
        // mostly residues, some unreduced values and extremes
        roll = $urandom_range(0, 9);
        if (roll == 0)
          val = VAL_W'($urandom_range(MODULUS, 30'h3FFF_FFFF));
        else if (roll == 1)
          val = $urandom_range(0, 1) ? MODULUS - 30'd1 : '0;
        else
          val = VAL_W'($urandom_range(0, MODULUS - 1));
        offer_command(cmd, pos, val, 1'b0, '0);
      end
    end

    // drain
    in_valid = 1'b0;
    steady = 1'b0;
    while (sums_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
